// ----- rtl/core/lbs_pkg.sv -----
package lbs_pkg;

    localparam int LED_COUNT_DEF = 64;
    localparam logic [31:0] NO_TIME = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_ENABLE  = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  led;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] period;
        logic [31:0] repeat_limit;
        logic [31:0] now;
    } t_in;

    typedef struct packed {
        logic [5:0] led_out;
        logic       action;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last;
    } t_out;

endpackage

// ----- rtl/core/led_blink_scheduler_core.sv -----
// Channel  | Ports                        | Transfer
// command  | i_start, o_busy, i_cmd       | edge with i_start high and o_busy low
// result   | o_res_valid, o_res           | every edge with o_res_valid high
//
// A tick and a clear each walk the table, one entry per cycle, and each gives one
// result per entry. An enable walks the entries once for the deadline scan, then
// writes one entry. A disable writes one entry without a walk. The last result of
// a tick or a clear shows in the first cycle after busy drops.
// The table is a set of memories with one read and one write port; the walk is set
// by that port. After reset a clearing pass over every entry runs while busy.
// The receiver cannot stall; each result is shown for one cycle.
module led_blink_scheduler_core #(
    parameter int LED_COUNT = lbs_pkg::LED_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lbs_pkg::t_in  i_cmd,
    output logic          o_busy,
    output logic          o_res_valid,
    output lbs_pkg::t_out o_res
);
    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [AW:0] LAST_IDX = (AW + 1)'(LED_COUNT - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]   r_state;
    logic [AW:0]  r_idx;
    logic         r_rd_v;
    logic [AW-1:0] r_rd_idx;
    lbs_pkg::t_in r_cmd;
    logic         r_found;
    logic [31:0]  r_hit;
    logic [31:0]  r_least;

    logic [23:0] m_col [LED_COUNT];
    logic [15:0] m_per [LED_COUNT];
    logic        m_act [LED_COUNT];
    logic [31:0] m_dl  [LED_COUNT];
    logic [31:0] m_cnt [LED_COUNT];
    logic [31:0] m_lim [LED_COUNT];

    logic [23:0] r_q_col;
    logic [15:0] r_q_per;
    logic        r_q_act;
    logic [31:0] r_q_dl, r_q_cnt, r_q_lim;

    logic          w_en;
    logic          w_dl_en;
    logic [AW-1:0] w_adr;
    logic [23:0]   w_col;
    logic [15:0]   w_per;
    logic          w_act;
    logic [31:0]   w_dl, w_cnt, w_lim;

    logic        rd_go;
    logic [AW-1:0] rd_adr;
    logic [31:0] now_q, cnt_inc, dl_half, dl_full;
    logic        past, stop;
    logic        go_dark, go_lit;
    logic        led_ok;

    assign led_ok = ({2'b00, r_cmd.led} < 8'(LED_COUNT));
    assign rd_go  = (r_state == S_WALK) && (r_idx <= LAST_IDX);
    assign rd_adr = r_idx[AW-1:0];
    assign now_q  = r_cmd.now;
    assign cnt_inc = r_q_cnt + 32'd1;
    assign past   = now_q > r_q_dl;
    assign stop   = (r_q_lim != lbs_pkg::NO_TIME) && (cnt_inc > r_q_lim);
    assign dl_half = r_q_dl - 32'(r_q_per >> 1);
    assign dl_full = r_q_dl - 32'(r_q_per);
    assign go_dark = (now_q > dl_half) || (r_q_dl == lbs_pkg::NO_TIME) || (r_q_col == 24'd0);
    assign go_lit  = now_q > dl_full;

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_q_col <= m_col[rd_adr];
            r_q_per <= m_per[rd_adr];
            r_q_act <= m_act[rd_adr];
            r_q_dl  <= m_dl[rd_adr];
            r_q_cnt <= m_cnt[rd_adr];
            r_q_lim <= m_lim[rd_adr];
        end
        if (w_en) begin
            m_col[w_adr] <= w_col;
            m_per[w_adr] <= w_per;
            m_act[w_adr] <= w_act;
            m_cnt[w_adr] <= w_cnt;
        end
        if (w_en && w_dl_en) begin
            m_dl[w_adr]  <= w_dl;
            m_lim[w_adr] <= w_lim;
        end
    end

    always_comb begin
        w_en  = 1'b0;
        w_dl_en = 1'b1;
        w_adr = r_rd_idx;
        w_col = r_q_col;
        w_per = r_q_per;
        w_act = r_q_act;
        w_dl  = r_q_dl;
        w_cnt = r_q_cnt;
        w_lim = r_q_lim;
        case (r_state)
            S_INIT, S_CLEAR: begin
                w_en  = 1'b1;
                w_adr = r_idx[AW-1:0];
                w_col = '0;
                w_per = '0;
                w_act = 1'b0;
                w_dl  = lbs_pkg::NO_TIME;
                w_cnt = '0;
                w_lim = lbs_pkg::NO_TIME;
            end
            S_WALK: begin
                if (r_rd_v && r_cmd.kind == lbs_pkg::KIND_TICK && past) begin
                    w_en  = 1'b1;
                    w_cnt = cnt_inc;
                    if (stop) begin
                        w_col = '0;
                        w_per = '0;
                        w_act = 1'b0;
                        w_cnt = '0;
                    end
                    w_dl = (r_q_act && !stop) ? now_q + 32'(r_q_per) : lbs_pkg::NO_TIME;
                end
            end
            S_WRITE: begin
                w_adr = r_cmd.led[AW-1:0];
                if (led_ok) begin
                    w_en = 1'b1;
                    w_cnt = '0;
                    if (r_cmd.kind == lbs_pkg::KIND_ENABLE) begin
                        w_col = {r_cmd.red, r_cmd.green, r_cmd.blue};
                        w_per = r_cmd.period;
                        w_act = 1'b1;
                        w_lim = r_cmd.repeat_limit;
                        w_dl  = r_found ? r_hit :
                                (r_least == lbs_pkg::NO_TIME) ? now_q : r_least;
                    end else begin
                        w_dl_en = 1'b0;
                        w_col = '0;
                        w_per = '0;
                        w_act = 1'b0;
                    end
                end
            end
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx <= '0;
            r_rd_v <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= (r_state == S_CLEAR) ||
                           (r_state == S_WALK && r_rd_v && r_cmd.kind == lbs_pkg::KIND_TICK);
            r_rd_v <= rd_go;
            r_rd_idx <= rd_adr;
            case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_idx <= '0;
                    r_found <= 1'b0;
                    r_least <= lbs_pkg::NO_TIME;
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.kind)
                            lbs_pkg::KIND_CLEAR:   r_state <= S_CLEAR;
                            lbs_pkg::KIND_DISABLE: r_state <= S_WRITE;
                            default:               r_state <= S_WALK;
                        endcase
                    end
                end
                S_CLEAR: begin
                    o_res.led_out <= 6'(r_idx);
                    o_res.action <= 1'b0;
                    o_res.red_out <= '0;
                    o_res.green_out <= '0;
                    o_res.blue_out <= '0;
                    o_res.last <= (r_idx == LAST_IDX);
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) r_state <= S_IDLE;
                end
                S_WALK: begin
                    if (rd_go) r_idx <= r_idx + 1'b1;
                    if (r_rd_v) begin
                        if (r_cmd.kind == lbs_pkg::KIND_TICK) begin
                            o_res.led_out <= 6'(r_rd_idx);
                            o_res.last <= ({1'b0, r_rd_idx} == LAST_IDX);
                            o_res.action <= !past && !go_dark && !go_lit;
                            {o_res.red_out, o_res.green_out, o_res.blue_out} <=
                                (past || (!go_dark && go_lit)) ? r_q_col : 24'd0;
                        end else if (!r_found) begin
                            if (r_q_act && r_q_per == r_cmd.period) begin
                                r_found <= 1'b1;
                                r_hit <= r_q_dl;
                            end else if (r_q_dl < r_least) begin
                                r_least <= r_q_dl;
                            end
                        end
                        if ({1'b0, r_rd_idx} == LAST_IDX) begin
                            r_state <= (r_cmd.kind == lbs_pkg::KIND_TICK) ? S_IDLE : S_WRITE;
                        end
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_clear_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.action) |-> (o_res.red_out == 8'd0 && o_res.green_out == 8'd0
        && o_res.blue_out == 8'd0))
        else $error("unchanged result carries a colour");
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> (r_state == S_IDLE))
        else $error("left idle without a command");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result after last");
endmodule

// ----- tb/led_blink_scheduler_core_tb.sv -----
module led_blink_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N        = 64;
    localparam int CYC_MAX  = 300000;
    localparam int CALM_IDX = 280;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    lbs_pkg::t_in  i_cmd;
    logic o_busy;
    logic o_res_valid;
    lbs_pkg::t_out o_res;

    led_blink_scheduler_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_res_valid(o_res_valid), .o_res(o_res)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    logic [23:0] tbl_colour [N];
    logic [15:0] tbl_period [N];
    logic        tbl_active [N];
    logic [31:0] tbl_deadline [N];
    logic [31:0] tbl_count [N];
    logic [31:0] tbl_limit [N];

    lbs_pkg::t_in  cmd_queue [$];
    bit   hold_queue [$];
    lbs_pkg::t_out led_expected [$];
    int   fail_count;
    int   cycles;
    int   sent;
    int   gap;
    bit   stim_done;

    task automatic table_reset();
        for (int i = 0; i < N; i++) begin
            tbl_colour[i] = '0; tbl_period[i] = '0; tbl_active[i] = 1'b0;
            tbl_deadline[i] = lbs_pkg::NO_TIME; tbl_count[i] = '0;
            tbl_limit[i] = lbs_pkg::NO_TIME;
        end
    endtask

    task automatic led_stop(int i);
        tbl_colour[i] = '0; tbl_period[i] = '0; tbl_active[i] = 1'b0; tbl_count[i] = '0;
    endtask

    task automatic push_led(int i, logic act, logic [23:0] c);
        lbs_pkg::t_out r;
        r.led_out = i[5:0]; r.action = act;
        r.red_out = c[23:16]; r.green_out = c[15:8]; r.blue_out = c[7:0];
        r.last = (i == N - 1);
        led_expected.push_back(r);
    endtask

    task automatic schedule_predict(lbs_pkg::t_in c);
        logic [31:0] least, dl, d, p;
        logic [23:0] col;
        bit found;
        case (c.kind)
            lbs_pkg::KIND_ENABLE: begin
                least = lbs_pkg::NO_TIME; found = 0; dl = '0;
                for (int i = 0; i < N; i++) begin
                    if (!found && tbl_active[i] && tbl_period[i] == c.period) begin
                        dl = tbl_deadline[i]; found = 1;
                    end
                    if (!found && tbl_deadline[i] < least) least = tbl_deadline[i];
                end
                if (!found) dl = (least == lbs_pkg::NO_TIME) ? c.now : least;
                tbl_deadline[c.led] = dl;
                tbl_colour[c.led] = {c.red, c.green, c.blue};
                tbl_period[c.led] = c.period;
                tbl_active[c.led] = 1'b1;
                tbl_limit[c.led] = c.repeat_limit;
                tbl_count[c.led] = '0;
            end
            lbs_pkg::KIND_DISABLE: led_stop(c.led);
            lbs_pkg::KIND_CLEAR: begin
                table_reset();
                for (int i = 0; i < N; i++) push_led(i, 1'b0, '0);
            end
            default: begin
                for (int i = 0; i < N; i++) begin
                    d = tbl_deadline[i]; col = tbl_colour[i]; p = {16'd0, tbl_period[i]};
                    if (c.now > d) begin
                        push_led(i, 1'b0, col);
                        tbl_count[i] = tbl_count[i] + 1;
                        if (tbl_limit[i] != lbs_pkg::NO_TIME && tbl_count[i] > tbl_limit[i])
                            led_stop(i);
                        tbl_deadline[i] = tbl_active[i] ? c.now + {16'd0, tbl_period[i]}
                                                        : lbs_pkg::NO_TIME;
                    end else if (c.now > d - (p >> 1) || d == lbs_pkg::NO_TIME || col == 0) begin
                        push_led(i, 1'b0, '0);
                    end else if (c.now > d - p) begin
                        push_led(i, 1'b0, col);
                    end else begin
                        push_led(i, 1'b1, '0);
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        logic nxt_start;
        lbs_pkg::t_in nxt_cmd;
        bit   hold;
        cycles <= cycles + 1;
        if (cycles > CYC_MAX) begin
            $display("led_blink_scheduler_core: mismatch");
            $finish;
        end
        nxt_start = i_start;
        nxt_cmd = i_cmd;
        if (i_rst_n !== 1'b1) begin
            nxt_start = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                schedule_predict(i_cmd);
                sent = sent + 1;
                nxt_start = 1'b0;
                if (sent < CALM_IDX && $urandom_range(0, 3) == 0)
                    gap = $urandom_range(1, 18);
            end
            if (!nxt_start) begin
                if (gap > 0) begin
                    gap = gap - 1;
                end else if (cmd_queue.size() > 0) begin
                    hold = hold_queue[0];
                    if (!hold || (led_expected.size() == 0 && !o_busy && !i_start)) begin
                        nxt_cmd = cmd_queue.pop_front();
                        void'(hold_queue.pop_front());
                        nxt_start = 1'b1;
                    end
                end else if (!i_start) begin
                    stim_done = 1;
                end
            end
        end
        i_start <= nxt_start;
        i_cmd <= nxt_cmd;
    end

    always @(posedge i_clk) begin
        lbs_pkg::t_out e;
        if (i_rst_n && o_res_valid) begin
            if (led_expected.size() == 0) begin
                $display("%0t unexpected result %p", $realtime, o_res);
                fail_count = fail_count + 1;
            end else begin
                e = led_expected.pop_front();
                if (o_res !== e) begin
                    $display("%0t expected %p actual %p", $realtime, e, o_res);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    task automatic add_cmd(logic [1:0] k, logic [5:0] l, logic [23:0] c, logic [15:0] p,
                           logic [31:0] lim, logic [31:0] t, bit hold = 0);
        lbs_pkg::t_in x;
        x.kind = k; x.led = l; x.red = c[23:16]; x.green = c[15:8]; x.blue = c[7:0];
        x.period = p; x.repeat_limit = lim; x.now = t;
        cmd_queue.push_back(x);
        hold_queue.push_back(hold);
    endtask

    initial begin
        logic [31:0] t;
        logic [15:0] p;
        logic [31:0] lim;
        int r;
        i_rst_n = 1'b0; i_start = 1'b0; i_cmd = '0;
        fail_count = 0; cycles = 0; sent = 0; gap = 0; stim_done = 0;
        table_reset();

        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd0);
        add_cmd(lbs_pkg::KIND_TICK, 6'h3F, 24'hFFFFFF, 16'hFFFF, lbs_pkg::NO_TIME,
                lbs_pkg::NO_TIME);
        add_cmd(lbs_pkg::KIND_ENABLE, 0, 24'hFF0000, 16'd10, lbs_pkg::NO_TIME, 32'd100);
        add_cmd(lbs_pkg::KIND_ENABLE, 6'd63, 24'h00FF00, 16'd10, 32'd0, 32'd5);
        add_cmd(lbs_pkg::KIND_ENABLE, 6'd5, 24'h0000FF, 16'hFFFF, 32'd2, 32'd50);
        add_cmd(lbs_pkg::KIND_ENABLE, 6'd6, 24'h000000, 16'd0, lbs_pkg::NO_TIME, 32'd7);
        add_cmd(lbs_pkg::KIND_ENABLE, 6'd7, 24'hFFFFFF, 16'd0, 32'd1, 32'd9);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd96);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd99);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd101);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd112);
        add_cmd(lbs_pkg::KIND_DISABLE, 6'd5, 0, 0, 0, 0);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd200, 1);
        add_cmd(lbs_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
        add_cmd(lbs_pkg::KIND_ENABLE, 6'd3, 24'h123456, 16'd40, lbs_pkg::NO_TIME,
                32'hFFFF_FFF0);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'hFFFF_FFF8);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, lbs_pkg::NO_TIME);
        add_cmd(lbs_pkg::KIND_TICK, 0, 0, 0, 0, 32'd10);
        add_cmd(lbs_pkg::KIND_CLEAR, 6'h2A, 24'hABCDEF, 16'h5555, 32'hAAAA_AAAA,
                32'h5555_5555);

        t = $urandom;
        for (int n = 0; n < 300; n++) begin
            r = $urandom_range(0, 99);
            p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
            lim = ($urandom_range(0, 2) == 0) ? lbs_pkg::NO_TIME : 32'($urandom_range(0, 6));
            if ($urandom_range(0, 19) == 0) lim = $urandom;
            if (r < 55) begin
                t = t + $urandom_range(0, 30);
                if ($urandom_range(0, 24) == 0) t = $urandom;
                add_cmd(lbs_pkg::KIND_TICK, 6'($urandom), 24'($urandom), 16'($urandom),
                        $urandom, t);
            end else if (r < 85) begin
                add_cmd(lbs_pkg::KIND_ENABLE, 6'($urandom), 24'($urandom), p, lim, t);
            end else if (r < 97) begin
                add_cmd(lbs_pkg::KIND_DISABLE, 6'($urandom), 24'($urandom), 16'($urandom),
                        $urandom, $urandom);
            end else begin
                add_cmd(lbs_pkg::KIND_CLEAR, 6'($urandom), 24'($urandom), 16'($urandom),
                        $urandom, $urandom);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        wait (led_expected.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("led_blink_scheduler_core: match");
        end else begin
            $display("led_blink_scheduler_core: mismatch");
        end
        $finish;
    end
endmodule
